// ----- src/ffsa_pkg.sv -----
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_cell, ffsa_ctrl and first_fit_segment_allocator_unit.
`default_nettype none
package ffsa_pkg;

   localparam int SEG_COUNT = 64;
   localparam int ADDR_W    = 16;
   localparam int OWNER_W   = 8;

   localparam logic [ADDR_W-1:0] HEAP_RESET = ADDR_W'(65535);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_NO_MATCH = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic               opcode;
      logic [OWNER_W-1:0] owner_id;
      logic [ADDR_W-1:0]  request_size;
      logic [ADDR_W-1:0]  block_start;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               used;
      logic [OWNER_W-1:0] owner;
      logic [ADDR_W-1:0]  size;
      logic [ADDR_W-1:0]  start;
   } seg_type;

   // what a cell shows its neighbors
   typedef struct packed {
      seg_type seg;
      logic    token;
      logic    pass;
   } link_type;

   typedef enum logic [3:0] {
      CMD_HOLD,
      CMD_INIT,
      CMD_START,
      CMD_SCAN,
      CMD_SPLIT,
      CMD_RELABEL,
      CMD_FREE,
      CMD_MERGE_NEXT,
      CMD_MERGE_PREV
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               opcode;
      logic [OWNER_W-1:0] owner;
      logic [ADDR_W-1:0]  size;
      logic [ADDR_W-1:0]  start;
      logic [ADDR_W-1:0]  heap;
   } bcast_type;

   typedef struct packed {
      logic              hit;
      logic              miss;
      logic              exact;
      logic              next_free;
      logic              prev_free;
      logic [ADDR_W-1:0] addr;
   } rpt_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_START,
      S_SCAN,
      S_SPLIT,
      S_RELABEL,
      S_FREE,
      S_MNEXT,
      S_MPREV,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// ----- src/ffsa_cell.sv -----
// One segment-table slot of the allocator chain; shifts with its neighbors.
// Depends on ffsa_pkg.
`default_nettype none
module ffsa_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  ffsa_pkg::bcast_type  bc,
   input  ffsa_pkg::link_type   left,
   input  ffsa_pkg::link_type   right,
   output ffsa_pkg::link_type   link,
   output ffsa_pkg::rpt_type    rpt
);
   import ffsa_pkg::*;

   seg_type seg_ff, seg_in;
   logic    tok_ff, tok_in;
   logic    passed_ff, passed_in;
   logic    match;

   always_comb begin
      if (bc.opcode == OP_ALLOC) begin
         match = seg_ff.valid && !seg_ff.used && (seg_ff.size >= bc.size);
      end else begin
         match = seg_ff.valid && seg_ff.used && (seg_ff.owner == bc.owner)
                 && (seg_ff.start == bc.start);
      end
   end

   assign link.seg   = seg_ff;
   assign link.token = tok_ff;
   assign link.pass  = (bc.cmd == CMD_SCAN) && tok_ff && seg_ff.valid && !match;

   assign rpt.hit       = tok_ff && match;
   assign rpt.miss      = tok_ff && !seg_ff.valid;
   assign rpt.exact     = tok_ff && (seg_ff.size == bc.size);
   assign rpt.next_free = tok_ff && right.seg.valid && !right.seg.used;
   assign rpt.prev_free = tok_ff && left.seg.valid && !left.seg.used;
   assign rpt.addr      = tok_ff ? seg_ff.start : '0;

   always_comb begin
      seg_in    = seg_ff;
      tok_in    = tok_ff;
      passed_in = passed_ff;
      case (bc.cmd)
         CMD_INIT: begin
            seg_in       = '0;
            seg_in.valid = left.pass;
            seg_in.size  = bc.heap;
            tok_in       = 1'b0;
            passed_in    = 1'b0;
         end
         CMD_START: begin
            tok_in    = left.pass;
            passed_in = 1'b0;
         end
         CMD_SCAN: begin
            if (link.pass) begin
               tok_in    = 1'b0;
               passed_in = 1'b1;
            end
            if (left.pass) tok_in = 1'b1;
         end
         CMD_SPLIT: begin
            if (tok_ff) begin
               seg_in.used  = 1'b1;
               seg_in.owner = bc.owner;
               seg_in.size  = bc.size;
            end else if (!passed_ff) begin
               seg_in = left.seg;
               if (left.token) begin
                  seg_in.start = left.seg.start + bc.size;
                  seg_in.size  = left.seg.size - bc.size;
               end
            end
         end
         CMD_RELABEL: begin
            if (tok_ff) begin
               seg_in.used  = 1'b1;
               seg_in.owner = bc.owner;
            end
         end
         CMD_FREE: begin
            if (tok_ff) begin
               seg_in.used  = 1'b0;
               seg_in.owner = '0;
            end
         end
         CMD_MERGE_NEXT: begin
            if (tok_ff) seg_in.size = seg_ff.size + right.seg.size;
            else if (!passed_ff) seg_in = right.seg;
         end
         CMD_MERGE_PREV: begin
            if (right.token) seg_in.size = seg_ff.size + right.seg.size;
            else if (tok_ff || !passed_ff) seg_in = right.seg;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff.valid <= 1'b0;
         tok_ff       <= 1'b0;
         passed_ff    <= 1'b0;
      end else begin
         seg_ff.valid <= seg_in.valid;
         tok_ff       <= tok_in;
         passed_ff    <= passed_in;
      end
      seg_ff.used  <= seg_in.used;
      seg_ff.owner <= seg_in.owner;
      seg_ff.size  <= seg_in.size;
      seg_ff.start <= seg_in.start;
   end

endmodule
`default_nettype wire

// ----- src/ffsa_ctrl.sv -----
// Sequencer for the allocator: takes beats, drives the cell chain, returns results.
// Depends on ffsa_pkg.
`default_nettype none
module ffsa_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  ffsa_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output ffsa_pkg::rsp_type          rsp_data,
   input  wire                        csr_wr_en,
   input  wire [ffsa_pkg::ADDR_W-1:0] csr_wr_data,
   input  ffsa_pkg::rpt_type          rpt,
   input  wire                        ran_off,
   input  wire                        full,
   output ffsa_pkg::bcast_type        bc
);
   import ffsa_pkg::*;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] heap_ff;
   logic              init_pend_ff, init_pend_in;
   logic [1:0]        stat_ff, stat_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              nf_ff, nf_in, pf_ff, pf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              req_take;

   assign req_stall = (state_ff != S_IDLE) || init_pend_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      init_pend_in = init_pend_ff;
      stat_in      = stat_ff;
      addr_in      = addr_ff;
      nf_in        = nf_ff;
      pf_in        = pf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (init_pend_ff) begin
               state_in = S_INIT;
            end else if (req_take) begin
               req_in  = req_data;
               stat_in = ST_OK;
               addr_in = '0;
               if (req_data.opcode == OP_ALLOC && req_data.request_size == '0) begin
                  stat_in  = ST_NO_FIT;
                  state_in = S_RESP;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_INIT: begin
            init_pend_in = 1'b0;
            state_in     = S_IDLE;
         end
         S_START: state_in = S_SCAN;
         S_SCAN: begin
            nf_in = rpt.next_free;
            pf_in = rpt.prev_free;
            if (rpt.hit) begin
               if (req_ff.opcode == OP_FREE) begin
                  state_in = S_FREE;
               end else if (rpt.exact) begin
                  addr_in  = rpt.addr;
                  state_in = S_RELABEL;
               end else if (full) begin
                  stat_in  = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  addr_in  = rpt.addr;
                  state_in = S_SPLIT;
               end
            end else if (rpt.miss || ran_off) begin
               stat_in  = (req_ff.opcode == OP_ALLOC) ? ST_NO_FIT : ST_NO_MATCH;
               state_in = S_RESP;
            end
         end
         S_SPLIT, S_RELABEL: state_in = S_RESP;
         S_FREE: begin
            if (nf_ff) state_in = S_MNEXT;
            else if (pf_ff) state_in = S_MPREV;
            else state_in = S_RESP;
         end
         S_MNEXT: state_in = pf_ff ? S_MPREV : S_RESP;
         S_MPREV: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = stat_ff;
               rsp_in.address = addr_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_wr_en) init_pend_in = 1'b1;
   end

   // chain command
   always_comb begin
      bc.opcode = req_ff.opcode;
      bc.owner  = req_ff.owner_id;
      bc.size   = req_ff.request_size;
      bc.start  = req_ff.block_start;
      bc.heap   = heap_ff;
      case (state_ff)
         S_INIT:    bc.cmd = CMD_INIT;
         S_START:   bc.cmd = CMD_START;
         S_SCAN:    bc.cmd = CMD_SCAN;
         S_SPLIT:   bc.cmd = CMD_SPLIT;
         S_RELABEL: bc.cmd = CMD_RELABEL;
         S_FREE:    bc.cmd = CMD_FREE;
         S_MNEXT:   bc.cmd = CMD_MERGE_NEXT;
         S_MPREV:   bc.cmd = CMD_MERGE_PREV;
         default:   bc.cmd = CMD_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_pend_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         heap_ff      <= HEAP_RESET;
      end else begin
         state_ff     <= state_in;
         init_pend_ff <= init_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) heap_ff <= csr_wr_data;
      end
      req_ff  <= req_in;
      stat_ff <= stat_in;
      addr_ff <= addr_in;
      nf_ff   <= nf_in;
      pf_ff   <= pf_in;
      rsp_ff  <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_hit_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !(rpt.hit && rpt.miss))
      else $error("token cell reports hit and miss together");
   a_mprev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MPREV) |-> pf_ff)
      else $error("merge with previous without a free previous segment");
   a_csr_init: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> init_pend_ff)
      else $error("heap size write did not schedule table init");
`endif

endmodule
`default_nettype wire

// ----- src/first_fit_segment_allocator_unit.sv -----
// First-fit segment allocator with coalescing.
//
// req_*  : request beats {opcode, owner_id, request_size, block_start}; a beat is
//          taken when req_valid is high and req_stall is low.
// rsp_*  : one result beat {status, address} per request, held in an output
//          register until taken (rsp_valid high, rsp_stall low).
// csr_*  : csr_wr_en writes the heap size and reinitializes the table to one
//          free segment; the rebuild waits until the sequencer is idle.
// The table is a chain of 64 cells, one segment each. A token walks the chain
// one cell per cycle to find the target segment; splits and merges shift the
// part of the chain beyond the target by one cell.
// The scan is followed by a split, relabel or free with merging of free neighbors.
// One request is handled at a time; the next beat is taken once the result
// is in the output register, even if rsp_stall holds it.
// Reset: heap size 65535 and one free segment; req_stall is high after reset
// until the table initializes.
// A stalled result holds the block in its final step until the beat is taken.
// Depends on ffsa_pkg, ffsa_cell, ffsa_ctrl.
`default_nettype none
module first_fit_segment_allocator_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  ffsa_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output ffsa_pkg::rsp_type          rsp_data,
   input  wire                        csr_wr_en,
   input  wire [ffsa_pkg::ADDR_W-1:0] csr_wr_data
);
   import ffsa_pkg::*;

   bcast_type bc;
   link_type  links [SEG_COUNT];
   rpt_type   rpts  [SEG_COUNT];
   rpt_type   rpt;
   link_type  head;

   always_comb begin
      head      = '0;
      head.pass = (bc.cmd == CMD_INIT) || (bc.cmd == CMD_START);
   end

   always_comb begin
      rpt = '0;
      for (int i = 0; i < SEG_COUNT; i++) rpt = rpt_type'(rpt | rpts[i]);
   end

   for (genvar g = 0; g < SEG_COUNT; g++) begin : g_cell
      link_type lft, rgt;
      if (g == 0) begin : g_l0
         assign lft = head;
      end else begin : g_ln
         assign lft = links[g-1];
      end
      if (g == SEG_COUNT-1) begin : g_rl
         assign rgt = '0;
      end else begin : g_rn
         assign rgt = links[g+1];
      end
      ffsa_cell u_cell (
         .clock (clock),
         .reset (reset),
         .bc    (bc),
         .left  (lft),
         .right (rgt),
         .link  (links[g]),
         .rpt   (rpts[g])
      );
   end

   ffsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rpt         (rpt),
      .ran_off     (links[SEG_COUNT-1].pass),
      .full        (links[SEG_COUNT-1].seg.valid),
      .bc          (bc)
   );

endmodule
`default_nettype wire
